// ===== rtl/pee_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_pkg
// Shared constants and types for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

    // Operand width and stack geometry
    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Parser mode
    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_NUMBER = 2'd1,
        MODE_SKIP   = 2'd2
    } parse_mode_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_PUSH = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    // Divider handshake
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/postfix_expression_evaluator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// Character-serial postfix evaluator with a RAM-backed operand stack.
// ----------------------------------------------------------------------------
// One character is taken per input beat. An operator stalls the input while
// the second operand is read from the registered-read stack RAM, the result
// is formed, then written back; '/' also waits in ST_DIV for the bit-serial
// divider. The top of stack is held in a register so only the entry below it
// needs a RAM read. A character marked final leads to ST_EMIT, which loads the
// result beat; the beat then waits in an output register until taken, and the
// next expression may start meanwhile.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core import pee_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_code,
    input  logic               final_char,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value,
    output logic               div_by_zero,
    output logic               stack_overflow
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

    state_t            state_reg, state_next;
    parse_mode_t       mode_reg, mode_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] accum_reg, accum_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic              div_err_reg, div_err_next;
    logic              ovf_reg, ovf_next;
    logic [7:0]        op_reg, op_next;
    logic              last_reg, last_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic              b_zero_reg, b_zero_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic              div_flag_reg, div_flag_next;
    logic              ovf_flag_reg, ovf_flag_next;

    logic              accept;
    logic              is_digit;
    logic              is_space;
    logic [DATA_W-1:0] digit_val;
    logic [DATA_W-1:0] accum_step;
    logic [DATA_W-1:0] b_val;
    logic              push_en;
    logic [DATA_W-1:0] push_data;
    logic              full;
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;
    logic [CNT_W-1:0]  below_top;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // Input decode
    assign accept     = in_valid & ~in_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign is_digit   = (char_code >= CH_0) && (char_code <= CH_9);
    assign is_space   = (char_code == CH_SPACE);
    assign digit_val  = {{(DATA_W-8){1'b0}}, char_code} - DATA_W'(CH_0);
    assign accum_step = (accum_reg << 3) + (accum_reg << 1) + digit_val;
    assign full       = (count_reg == FULL_CNT);
    assign below_top  = count_reg - CNT_W'(2);
    assign b_val      = b_zero_reg ? '0 : ram_rd_data;

    // Stack storage
    pee_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_W)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (push_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Divider
    pee_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign ram_wr_en = push_en & ~full;

    // Sequencer and next-state logic
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        accum_next     = accum_reg;
        top_next       = top_reg;
        div_err_next   = div_err_reg;
        ovf_next       = ovf_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        a_next         = a_reg;
        b_zero_next    = b_zero_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg & out_stall;
        value_next     = value_reg;
        div_flag_next  = div_flag_reg;
        ovf_flag_next  = ovf_flag_reg;
        push_en        = 1'b0;
        push_data      = accum_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = below_top[ADDR_W-1:0];
        div_req.start    = 1'b0;
        div_req.dividend = b_val;
        div_req.divisor  = a_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = final_char;
                    if (final_char)
                    begin
                        state_next = ST_EMIT;
                    end
                    case (mode_reg)
                        MODE_NUMBER:
                        begin
                            if (is_space)
                            begin
                                push_en    = 1'b1;
                                push_data  = accum_reg;
                                accum_next = '0;
                                mode_next  = MODE_START;
                            end
                            else
                            begin
                                accum_next = accum_step;
                                // number still open at the end is pushed
                                if (final_char)
                                begin
                                    push_en   = 1'b1;
                                    push_data = accum_step;
                                end
                            end
                        end
                        MODE_SKIP:
                        begin
                            mode_next = MODE_START;
                        end
                        default:
                        begin
                            if (is_digit)
                            begin
                                accum_next = digit_val;
                                mode_next  = MODE_NUMBER;
                                if (final_char)
                                begin
                                    push_en   = 1'b1;
                                    push_data = digit_val;
                                end
                            end
                            else
                            begin
                                // operator: pop a from top register, fetch b
                                op_next     = char_code;
                                a_next      = (count_reg != '0) ? top_reg : '0;
                                b_zero_next = (count_reg < CNT_W'(2));
                                count_next  = (count_reg < CNT_W'(2)) ? '0 : below_top;
                                ram_rd_en   = 1'b1;
                                state_next  = ST_READ;
                            end
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                state_next = ST_PUSH;
                case (op_reg)
                    CH_PLUS:  res_next = b_val + a_reg;
                    CH_MINUS: res_next = b_val - a_reg;
                    CH_STAR:  res_next = b_val * a_reg;
                    CH_CARET: res_next = b_val ^ a_reg;
                    CH_SLASH:
                    begin
                        if (a_reg == '0)
                        begin
                            res_next     = '0;
                            div_err_next = 1'b1;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end
                    default:  res_next = '0;
                endcase
            end

            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_next   = div_rsp.quotient;
                    state_next = ST_PUSH;
                end
            end

            ST_PUSH:
            begin
                push_en    = 1'b1;
                push_data  = res_reg;
                mode_next  = MODE_SKIP;
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    value_next     = (count_reg != '0) ? top_reg : '0;
                    div_flag_next  = div_err_reg;
                    ovf_flag_next  = ovf_reg;
                    count_next     = '0;
                    accum_next     = '0;
                    mode_next      = MODE_START;
                    div_err_next   = 1'b0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Common push: top register and RAM follow each accepted push
        if (push_en)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                top_next   = push_data;
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_START;
            count_reg     <= '0;
            accum_reg     <= '0;
            div_err_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            accum_reg     <= accum_next;
            div_err_reg   <= div_err_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        op_reg       <= op_next;
        last_reg     <= last_next;
        a_reg        <= a_next;
        b_zero_reg   <= b_zero_next;
        res_reg      <= res_next;
        value_reg    <= value_next;
        div_flag_reg <= div_flag_next;
        ovf_flag_reg <= ovf_flag_next;
    end

    assign out_valid      = out_valid_reg;
    assign value          = $signed(value_reg);
    assign div_by_zero    = div_flag_reg;
    assign stack_overflow = ovf_flag_reg;

endmodule

// ===== rtl/pee_stack_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_stack_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pee_stack_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/pee_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_divider
// Signed restoring divider, one quotient bit per cycle, truncates to zero.
// ----------------------------------------------------------------------------
module pee_divider import pee_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int ITER_W = $clog2(DATA_W);
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(DATA_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic              neg_reg;

    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   diff;
    logic              fits;
    logic [DATA_W-1:0] dvd_mag;
    logic [DATA_W-1:0] dvs_mag;

    // Magnitudes of the operands; the most negative value maps to 2^(W-1)
    assign dvd_mag = req.dividend[DATA_W-1] ? (~req.dividend + 1'b1) : req.dividend;
    assign dvs_mag = req.divisor[DATA_W-1]  ? (~req.divisor + 1'b1)  : req.divisor;

    // One restoring step
    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};
    assign fits      = ~diff[DATA_W];

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == LAST_ITER)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath; the dividend shifts out as the quotient shifts in
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= dvd_mag;
            rem_reg <= '0;
            dvs_reg <= dvs_mag;
            neg_reg <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the postfix expression evaluator core.
// ----------------------------------------------------------------------------
// Expressions are fed one character per beat, with the final flag on the last
// character of each. A scoreboard evaluates the same characters on its own
// operand stack and queues one expected result beat per expression. Every
// result beat is compared field by field with the oldest expected one.
// Stimulus opens with a handful of short directed expressions. Random
// expressions follow. Most are well formed with random operands and
// operators. A few nearly fill or overflow the stack, and the rest are noise.
// Both sides insert random idle cycles, with stretches of full rate.
// ----------------------------------------------------------------------------
module tb;
    import pee_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_CHARS = 1100;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [31:0] value;
        logic        div_by_zero;
        logic        stack_overflow;
    } expr_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow evaluator plus queue of expected result beats
    // ------------------------------------------------------------------------
    class postfix_scoreboard;
        logic [31:0]  stk [STACK_DEPTH];
        int unsigned  depth_used;
        logic [31:0]  accum;
        parse_mode_t  mode;
        bit           div_seen;
        bit           ovf_seen;
        expr_result_t expected_results [$];
        int           errors;
        int           n_exprs;
        int           n_div_hits;
        int           n_ovf_hits;

        function new();
            depth_used = 0;
            accum      = '0;
            mode       = MODE_START;
            div_seen   = 1'b0;
            ovf_seen   = 1'b0;
            errors     = 0;
            n_exprs    = 0;
            n_div_hits = 0;
            n_ovf_hits = 0;
        endfunction

        function void push_operand(logic [31:0] v);
            if (depth_used < STACK_DEPTH)
            begin
                stk[depth_used] = v;
                depth_used++;
            end
            else
            begin
                ovf_seen = 1'b1;
            end
        endfunction

        // Empty stack reads as zero
        function logic [31:0] pop_operand();
            if (depth_used == 0)
                return '0;
            depth_used--;
            return stk[depth_used];
        endfunction

        function logic [31:0] combine(logic [31:0] lhs, logic [31:0] rhs, logic [7:0] op);
            case (op)
                CH_PLUS:  return lhs + rhs;
                CH_MINUS: return lhs - rhs;
                CH_STAR:  return lhs * rhs;
                CH_CARET: return lhs ^ rhs;
                CH_SLASH:
                begin
                    if (rhs == '0)
                    begin
                        div_seen = 1'b1;
                        return '0;
                    end
                    // most negative / -1 stays most negative
                    if (lhs == 32'h8000_0000 && rhs == 32'hFFFF_FFFF)
                        return lhs;
                    return $signed(lhs) / $signed(rhs);
                end
                default:  return '0;
            endcase
        endfunction

        // One accepted input beat
        function void note_char(logic [7:0] c, logic last);
            logic [31:0]  lhs;
            logic [31:0]  rhs;
            expr_result_t res;
            case (mode)
                MODE_NUMBER:
                begin
                    if (c == CH_SPACE)
                    begin
                        push_operand(accum);
                        accum = '0;
                        mode  = MODE_START;
                    end
                    else
                    begin
                        accum = accum * 32'd10 + 32'(c) - 32'(CH_0);
                    end
                end
                MODE_SKIP:
                begin
                    mode = MODE_START;
                end
                default:
                begin
                    if (c >= CH_0 && c <= CH_9)
                    begin
                        accum = 32'(c) - 32'(CH_0);
                        mode  = MODE_NUMBER;
                    end
                    else
                    begin
                        rhs = pop_operand();
                        lhs = pop_operand();
                        push_operand(combine(lhs, rhs, c));
                        mode = MODE_SKIP;
                    end
                end
            endcase

            if (last)
            begin
                // number still being gathered is pushed first
                if (mode == MODE_NUMBER)
                    push_operand(accum);
                res.value          = (depth_used > 0) ? stk[depth_used - 1] : '0;
                res.div_by_zero    = div_seen;
                res.stack_overflow = ovf_seen;
                expected_results.push_back(res);
                n_exprs++;
                if (div_seen)
                    n_div_hits++;
                if (ovf_seen)
                    n_ovf_hits++;
                depth_used = 0;
                accum      = '0;
                mode       = MODE_START;
                div_seen   = 1'b0;
                ovf_seen   = 1'b0;
            end
        endfunction

        // One accepted result beat
        function void check_result(logic [31:0] got_value, logic got_div, logic got_ovf);
            expr_result_t exp_res;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat: value %0d", $signed(got_value));
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (got_value !== exp_res.value)
            begin
                $error("value: expected %0d, got %0d", $signed(exp_res.value), $signed(got_value));
                errors++;
            end
            if (got_div !== exp_res.div_by_zero)
            begin
                $error("div_by_zero: expected %0b, got %0b", exp_res.div_by_zero, got_div);
                errors++;
            end
            if (got_ovf !== exp_res.stack_overflow)
            begin
                $error("stack_overflow: expected %0b, got %0b", exp_res.stack_overflow, got_ovf);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               in_valid       = 1'b0;
    logic               in_stall;
    logic [7:0]         char_code      = '0;
    logic               final_char     = 1'b0;
    logic               out_valid;
    logic               out_stall      = 1'b0;
    logic signed [31:0] value;
    logic               div_by_zero;
    logic               stack_overflow;

    postfix_scoreboard sb = new();

    bit          idle_on    = 1'b1;
    int          chars_sent = 0;
    int          cycles     = 0;
    int          hold       = 0;
    logic [7:0]  expr_q [$];

    postfix_expression_evaluator_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .final_char     (final_char),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .value          (value),
        .div_by_zero    (div_by_zero),
        .stack_overflow (stack_overflow)
    );

    always #5 clk = ~clk;

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycles, sb.expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Input beat monitor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_char(char_code, final_char);
    end

    // Result beat monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(value, div_by_zero, stack_overflow);
    end

    // Receiver back-pressure: after each taken beat, hold out_stall for a random wait_cycles draw
    always @(posedge clk)
    begin
        int wait_cycles;
        wait_cycles = $urandom_range(0, 6);
        if (!rst_n || !idle_on)
        begin
            hold      <= 0;
            out_stall <= 1'b0;
        end
        else if (out_valid && !out_stall)
        begin
            hold      <= wait_cycles;
            out_stall <= (wait_cycles != 0);
        end
        else if (hold > 0)
        begin
            hold      <= hold - 1;
            out_stall <= (hold > 1);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers and expression builders
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        char_code  <= c;
        final_char <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_expr();
        for (int i = 0; i < expr_q.size(); i++)
            send_char(expr_q[i], i == expr_q.size() - 1);
    endtask

    task automatic send_text(input string s);
        expr_q.delete();
        for (int i = 0; i < s.len(); i++)
            expr_q.push_back(s[i]);
        send_expr();
    endtask

    function automatic void add_value(logic [31:0] v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            expr_q.push_back(s[i]);
    endfunction

    // Operand pool: edge values, long wrapping numbers, short numbers
    function automatic void add_operand();
        int r;
        int ndig;
        r = $urandom_range(0, 11);
        case (r)
            0:       add_value(32'd0);
            1:       add_value(32'd1);
            2:       add_value(32'hFFFF_FFFF);
            3:       add_value(32'h8000_0000);
            4:       add_value(32'h7FFF_FFFF);
            default:
            begin
                ndig = (r < 7) ? $urandom_range(6, 11) : $urandom_range(1, 3);
                for (int i = 0; i < ndig; i++)
                    expr_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_operator();
        logic [7:0] c;
        case ($urandom_range(0, 15))
            0, 1, 2:    c = CH_PLUS;
            3, 4, 5:    c = CH_MINUS;
            6, 7, 8:    c = CH_STAR;
            9, 10, 11:  c = CH_SLASH;
            12, 13, 14: c = CH_CARET;
            default:
            begin
                // any other non-digit acts as an unknown operator
                c = 8'($urandom_range(0, 255));
                while (c >= CH_0 && c <= CH_9)
                    c = 8'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    // Character skipped after an operator: usually a space
    function automatic logic [7:0] pick_skipped();
        if ($urandom_range(0, 5) == 0)
            return 8'($urandom_range(0, 255));
        return CH_SPACE;
    endfunction

    function automatic void build_wellformed();
        int operands;
        int depth;
        int pushed;
        expr_q.delete();
        operands = $urandom_range(1, 6);
        depth    = 0;
        pushed   = 0;
        while (pushed < operands || depth > 1)
        begin
            if (pushed < operands && (depth < 2 || $urandom_range(0, 1)))
            begin
                add_operand();
                expr_q.push_back(CH_SPACE);
                pushed++;
                depth++;
            end
            else
            begin
                expr_q.push_back(pick_operator());
                expr_q.push_back(pick_skipped());
                depth--;
            end
        end
        // sometimes the flag lands on the last token itself
        if ($urandom_range(0, 1))
            void'(expr_q.pop_back());
    endfunction

    // Pushes from one short of a full stack to past it, then up to three operators
    function automatic void build_deep();
        int pushes;
        expr_q.delete();
        pushes = STACK_DEPTH - 1 + $urandom_range(0, 5);
        for (int i = 0; i < pushes; i++)
        begin
            expr_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
            expr_q.push_back(CH_SPACE);
        end
        for (int i = $urandom_range(0, 3); i > 0; i--)
        begin
            expr_q.push_back(pick_operator());
            expr_q.push_back(CH_SPACE);
        end
        if ($urandom_range(0, 1))
        begin
            expr_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 1))
                expr_q.push_back(CH_SPACE);
        end
    endfunction

    // Noise: random bytes, or a jumble of the characters the parser knows
    function automatic void build_noise();
        string alphabet;
        int    len;
        bit    raw;
        alphabet = "0123456789 +-*/^";
        expr_q.delete();
        len = $urandom_range(1, 10);
        raw = $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
        begin
            if (raw)
                expr_q.push_back(8'($urandom_range(0, 255)));
            else
                expr_q.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int r;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pop, pending number, each operator, zero divisor,
        // unknown operators at both ends of the code range
        send_text("+");
        send_text("9");
        send_text("7 3 -");
        send_text("6 0 /");
        send_text("5 3 ^");
        send_text("4 5 *");
        expr_q.delete();
        expr_q.push_back(8'h00);
        send_expr();
        expr_q.delete();
        expr_q.push_back(8'hFF);
        send_expr();

        // Most negative divided by minus one, and one deep stack
        send_text("2147483648 4294967295 /");
        build_deep();
        send_expr();

        // Random part
        while (chars_sent < RANDOM_CHARS)
        begin
            idle_on = ($urandom_range(0, 4) != 0);
            r = $urandom_range(0, 99);
            if (r == 0)
                build_deep();
            else if (r < 76)
                build_wellformed();
            else
                build_noise();
            send_expr();
        end
        in_valid <= 1'b0;

        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d expressions over %0d characters in %0d cycles.",
                 sb.n_exprs, chars_sent, cycles);
        $display("Expressions with a zero divisor: %0d, with a dropped push: %0d.",
                 sb.n_div_hits, sb.n_ovf_hits);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
